@@ sv/fba_pkg.sv @@
package fba_pkg;

    localparam int NUM_FRAMES   = 65536;
    localparam int WORD_BITS    = 32;
    localparam int INDEX_W      = 16;
    localparam int INDEX_SPAN   = 1 << INDEX_W;
    localparam int NUM_WORDS    = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int SEARCH_LIMIT = (NUM_FRAMES < INDEX_SPAN) ? NUM_FRAMES : INDEX_SPAN;
    localparam int LAST_WORD    = (SEARCH_LIMIT - 1) / WORD_BITS;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int ADDR_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam logic [1:0] OP_FIND      = 2'd0;
    localparam logic [1:0] OP_MARK_USED = 2'd1;
    localparam logic [1:0] OP_MARK_FREE = 2'd2;
    localparam logic [1:0] OP_CHECK     = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [INDEX_W-1:0] frame_index;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] frame_out;
        logic               used_flag;
    } rsp_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [ADDR_W-1:0]    raddr;
    } ram_cmd_t;

endpackage

@@ sv/fba_bitmap_ram.sv @@
module fba_bitmap_ram (
    input  logic                          clk,
    input  fba_pkg::ram_cmd_t             cmd,
    output logic [fba_pkg::WORD_BITS-1:0] rd_data
);
    import fba_pkg::*;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        rd_data_reg <= mem[cmd.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/fba_ctrl.sv @@
module fba_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fba_pkg::req_t                 req,
    output logic                          done,
    output fba_pkg::rsp_t                 rsp,
    output fba_pkg::ram_cmd_t             ram_cmd,
    input  logic [fba_pkg::WORD_BITS-1:0] rd_data
);
    import fba_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    localparam int CAND_W = ADDR_W + BIT_W;

    logic [1:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic                 first_reg, first_next;
    logic                 valid_reg, valid_next;
    logic [1:0]           op_reg, op_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 accept;
    logic                 req_valid;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic                 any_free;
    logic [BIT_W-1:0]     free_pos;
    logic [CAND_W-1:0]    cand;
    logic                 cand_ok;

    // lowest set bit of a word
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    assign accept    = start && !busy;
    assign req_valid = (32'(req.frame_index) < SEARCH_LIMIT);
    assign bit_mask  = WORD_BITS'(1) << bit_reg;

    always_comb
    begin
        if (first_reg)
        begin
            free_bits = ~rd_data & ({WORD_BITS{1'b1}} << bit_reg);
        end
        else
        begin
            free_bits = ~rd_data;
        end
    end

    assign any_free = |free_bits;
    assign free_pos = lowest_set(free_bits);
    assign cand     = {addr_reg, free_pos};
    assign cand_ok  = any_free && (32'(cand) < SEARCH_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        first_next = first_reg;
        valid_next = valid_reg;
        op_next    = op_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        ram_cmd.we    = 1'b0;
        ram_cmd.waddr = addr_reg;
        ram_cmd.wdata = '0;
        ram_cmd.raddr = addr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_cmd.we = 1'b1;
                addr_next  = addr_reg + 1'b1;
                if (32'(addr_reg) == NUM_WORDS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_cmd.raddr = ADDR_W'(req.frame_index >> BIT_W);
                if (accept)
                begin
                    addr_next  = ADDR_W'(req.frame_index >> BIT_W);
                    bit_next   = req.frame_index[BIT_W-1:0];
                    op_next    = req.op;
                    valid_next = req_valid;
                    first_next = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // next word is fetched while this one is examined
                ram_cmd.raddr = addr_reg + 1'b1;
                rsp_next      = '0;
                unique case (op_reg)
                    OP_FIND:
                    begin
                        if (!valid_reg)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (cand_ok)
                        begin
                            rsp_next.found     = 1'b1;
                            rsp_next.frame_out = INDEX_W'(cand);
                            done_next          = 1'b1;
                            state_next         = ST_IDLE;
                        end
                        else if (32'(addr_reg) >= LAST_WORD)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            addr_next  = addr_reg + 1'b1;
                            first_next = 1'b0;
                        end
                    end
                    OP_MARK_USED:
                    begin
                        ram_cmd.we    = valid_reg;
                        ram_cmd.wdata = rd_data | bit_mask;
                        done_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    OP_MARK_FREE:
                    begin
                        ram_cmd.we    = valid_reg;
                        ram_cmd.wdata = rd_data & ~bit_mask;
                        done_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    default:
                    begin
                        rsp_next.used_flag = valid_reg && |(rd_data & bit_mask);
                        done_next          = 1'b1;
                        state_next         = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_CLEAR;
                addr_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            first_reg <= 1'b0;
            valid_reg <= 1'b0;
            op_reg    <= OP_FIND;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            first_reg <= first_next;
            valid_reg <= valid_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_EVAL))
        else $error("result strobe without evaluation");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request accepted but block not busy");

    a_found_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.found) |-> (rsp_reg.used_flag == 1'b0))
        else $error("find result carries used flag");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !rsp_reg.found) |-> (rsp_reg.frame_out == '0))
        else $error("frame out nonzero without found");

    a_write_while_clear_or_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ram_cmd.we |-> (state_reg == ST_CLEAR || state_reg == ST_EVAL))
        else $error("bitmap write outside clear or update");

endmodule

@@ sv/frame_bitmap_allocator_unit.sv @@
// mark and check: the word is read as the request is taken, then updated or tested in the
// evaluation state; find scans one bitmap word per cycle from the start index to the last word
// throughput: one request at a time, busy until the result strobe is issued
// reset: a clearing pass writes every bitmap word to zero, busy until the last word is written
// results are shown for one cycle on done; the receiver cannot stall
module frame_bitmap_allocator_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fba_pkg::req_t req,
    output logic          done,
    output fba_pkg::rsp_t rsp
);
    import fba_pkg::*;

    ram_cmd_t             ram_cmd;
    logic [WORD_BITS-1:0] rd_data;

    fba_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .ram_cmd (ram_cmd),
        .rd_data (rd_data)
    );

    fba_bitmap_ram u_ram (
        .clk     (clk),
        .cmd     (ram_cmd),
        .rd_data (rd_data)
    );

endmodule

@@ tb/sv/frame_bitmap_allocator_unit_tb.sv @@
`timescale 1ns / 100ps

module frame_bitmap_allocator_unit_tb;

    import fba_pkg::*;

    localparam int RANDOM_ITEMS = 270;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE_WAIT  = 2100;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;

    req_t  queued_req[$];
    rsp_t  expected_rsp[$];
    bit [NUM_FRAMES-1:0] used_map;
    bit    req_taken;
    int    idle_pct;
    int    error_count;
    int    item_count;
    int    cycle_count;

    frame_bitmap_allocator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic rsp_t allocator_predict(req_t r);
        rsp_t res;
        int   f;
        res = '0;
        case (r.op)
            OP_FIND:
            begin
                for (f = int'(r.frame_index); f < SEARCH_LIMIT; f++)
                begin
                    if (!used_map[f])
                    begin
                        res.found     = 1'b1;
                        res.frame_out = f[INDEX_W-1:0];
                        break;
                    end
                end
            end
            OP_MARK_USED:
            begin
                if (int'(r.frame_index) < NUM_FRAMES)
                    used_map[r.frame_index] = 1'b1;
            end
            OP_MARK_FREE:
            begin
                if (int'(r.frame_index) < NUM_FRAMES)
                    used_map[r.frame_index] = 1'b0;
            end
            default:
            begin
                if (int'(r.frame_index) < NUM_FRAMES)
                    res.used_flag = used_map[r.frame_index];
            end
        endcase
        return res;
    endfunction

    task automatic check_rsp(rsp_t got);
        rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            $error("result strobe with no request outstanding");
            error_count++;
        end
        else
        begin
            want = expected_rsp.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                error_count++;
            end
            if (got.frame_out !== want.frame_out)
            begin
                $error("frame_out: expected %0d, actual %0d", want.frame_out, got.frame_out);
                error_count++;
            end
            if (got.used_flag !== want.used_flag)
            begin
                $error("used_flag: expected %0d, actual %0d", want.used_flag, got.used_flag);
                error_count++;
            end
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || req_taken)
            begin
                if (queued_req.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    req   <= queued_req.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (done)
                check_rsp(rsp);
            if (start && !busy)
            begin
                req_taken = 1'b1;
                expected_rsp.push_back(allocator_predict(req));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_req(logic [1:0] op, int idx);
        req_t r;
        r.op          = op;
        r.frame_index = idx[INDEX_W-1:0];
        queued_req.push_back(r);
        item_count++;
    endtask

    task automatic wait_drain();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (queued_req.size() != 0 || start || expected_rsp.size() != 0);
    endtask

    // mark a run used, find past it, check a frame in it, punch a hole, find the hole and check it
    task automatic add_run();
        int base;
        int len;
        int hole;
        int i;
        if ($urandom_range(0, 9) < 2)
        begin
            base = $urandom_range(INDEX_SPAN - 16, INDEX_SPAN - 1);
            len  = INDEX_SPAN - base;
        end
        else
        begin
            base = $urandom_range(0, INDEX_SPAN - 1);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
            if (base + len > INDEX_SPAN)
                len = INDEX_SPAN - base;
        end
        for (i = 0; i < len; i++)
            push_req(OP_MARK_USED, base + i);
        push_req(OP_FIND, base);
        push_req(OP_CHECK, base + $urandom_range(0, len - 1));
        hole = base + $urandom_range(0, len - 1);
        push_req(OP_MARK_FREE, hole);
        push_req(OP_FIND, base);
        push_req(OP_CHECK, hole);
    endtask

    task automatic add_random(int count);
        int stop_at;
        stop_at = item_count + count;
        while (item_count < stop_at)
        begin
            if ($urandom_range(0, 99) < 20)
                push_req(2'($urandom_range(0, 3)), $urandom_range(0, INDEX_SPAN - 1));
            else
                add_run();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        req_taken   = 1'b0;
        idle_pct    = 0;
        error_count = 0;
        item_count  = 0;
        cycle_count = 0;
        used_map    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty bitmap, both ends of the index range
        push_req(OP_CHECK, 0);
        push_req(OP_FIND, 0);
        push_req(OP_FIND, INDEX_SPAN - 1);
        push_req(OP_MARK_USED, 0);
        push_req(OP_CHECK, 0);
        // top frame used, nothing free above
        push_req(OP_MARK_USED, INDEX_SPAN - 1);
        push_req(OP_CHECK, INDEX_SPAN - 1);
        push_req(OP_FIND, INDEX_SPAN - 1);
        push_req(OP_MARK_FREE, INDEX_SPAN - 1);
        push_req(OP_FIND, INDEX_SPAN - 1);
        // run across a word boundary
        push_req(OP_MARK_USED, 30);
        push_req(OP_MARK_USED, 31);
        push_req(OP_MARK_USED, 32);
        push_req(OP_FIND, 30);
        push_req(OP_MARK_FREE, 31);
        push_req(OP_FIND, 30);
        push_req(OP_MARK_FREE, 0);
        push_req(OP_CHECK, 0);
        push_req(OP_MARK_FREE, 0);
        push_req(OP_CHECK, int'(16'hAAAA));
        push_req(OP_FIND, int'(16'h5555));
        wait_drain();

        idle_pct = 0;
        add_random(RANDOM_ITEMS / 4);
        wait_drain();
        idle_pct = 84;
        add_random(RANDOM_ITEMS / 4);
        wait_drain();
        idle_pct = 7;
        add_random(RANDOM_ITEMS / 4);
        wait_drain();
        idle_pct = 0;
        add_random(RANDOM_ITEMS / 4);
        wait_drain();

        repeat (SETTLE_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
